[rtl/ccca_pkg.sv]
// Shared constants and controller/datapath interface types for the coil-combine accumulator.
`timescale 1ns / 1ps

package ccca_pkg;

   // Stream payload widths
   localparam int SAMPLE_W    = 16;
   localparam int REQ_DATA_W  = 4 * SAMPLE_W;
   localparam int ACC_W       = 37;
   localparam int IDX_W       = 16;
   localparam int RSP_FIELD_W = 2 * ACC_W + IDX_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // Arithmetic widths
   localparam int PROD_W = 2 * SAMPLE_W;
   localparam int TERM_W = PROD_W + 1;

   // Geometry
   localparam int DIM_W      = 11;
   localparam int POS_W      = 10;
   localparam int DIM_LIMIT  = 1024;
   localparam int PLANE_W    = 21;
   localparam int VOL_W      = 31;
   localparam int SUM_IDX_W  = 32;

   // Channels
   localparam int CHAN_W       = 5;
   localparam int CNT_W        = 6;
   localparam int MAX_CHANNELS = 32;

   // Per-voxel accumulator store
   localparam int MEM_DEPTH = 1 << IDX_W;

   // Configuration port
   localparam int CFG_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_IMAGE_WIDTH   = 3'd0,
      CFG_IMAGE_HEIGHT  = 3'd1,
      CFG_IMAGE_DEPTH   = 3'd2,
      CFG_CROP_WIDTH    = 3'd3,
      CFG_CROP_HEIGHT   = 3'd4,
      CFG_CROP_DEPTH    = 3'd5,
      CFG_CHANNEL_COUNT = 3'd6,
      CFG_ROOT_MODE     = 3'd7
   } cfg_index_type;

   // Square root unit: radicand is the non-negative part of an accumulator
   localparam int RAD_W      = ACC_W - 1;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_item;
      logic multiply;
      logic combine;
      logic mem_read;
      logic accum;
      logic mem_write;
      logic root_start;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic in_range;
      logic last_ch;
      logic root_mode;
      logic root_done;
      logic out_free;
   } status_type;

endpackage

[rtl/ccca_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module ccca_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ccca_pkg::RAD_W-1:0]   radicand,
   output logic [ccca_pkg::ROOT_W-1:0]  root,
   output logic                         done
);
   import ccca_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_CNT_W-1:0] count_ff, count_in;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [REM_W+1:0]      rem_shift;
   logic [REM_W+1:0]      trial;

   // One digit step: bring down two radicand bits, try root*4+1
   always_comb begin
      rem_shift = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial     = (REM_W+2)'({root_ff, 2'b01});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = REM_W'(rem_shift - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_shift);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         count_in = ROOT_CNT_W'(count_ff + 1'b1);
         if (count_ff == ROOT_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

[rtl/ccca_datapath.sv]
// Datapath: settings, raster counters, complex products, voxel store, output register.
`timescale 1ns / 1ps

module ccca_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [ccca_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [ccca_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [ccca_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [ccca_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  ccca_pkg::cmd_type                   cmd,
   output ccca_pkg::status_type                status
);
   import ccca_pkg::*;

   // Size zero acts as one, sizes above the limit clamp
   function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0)
         r = DIM_W'(1);
      else if (v > DIM_W'(DIM_LIMIT))
         r = DIM_W'(DIM_LIMIT);
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] crop_eff(input logic [DIM_W-1:0] c,
                                                 input logic [DIM_W-1:0] img);
      logic [DIM_W-1:0] r;
      r = (c == '0) ? DIM_W'(1) : c;
      if (r > img)
         r = img;
      return r;
   endfunction

   function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W:0] v);
      logic signed [ACC_W-1:0] r;
      r = v[ACC_W-1:0];
      if (v[ACC_W] != v[ACC_W-1])
         r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      return r;
   endfunction

   // Configuration registers
   logic [DIM_W-1:0] image_width_ff, image_height_ff, image_depth_ff;
   logic [DIM_W-1:0] crop_width_ff, crop_height_ff, crop_depth_ff;
   logic [CNT_W-1:0] channel_count_ff;
   logic             root_mode_ff;

   // Raster position and channel
   logic [POS_W-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic [POS_W-1:0]  pos_x_in, pos_y_in, pos_z_in;
   logic [CHAN_W-1:0] channel_ff, channel_in;

   // Effective geometry
   logic [DIM_W-1:0] iw_c, ih_c, id_c, cw_c, ch_c, cd_c;
   logic [CNT_W-1:0] nch_c;
   logic [POS_W-1:0] x0_c, y0_c, z0_c;
   logic [DIM_W-1:0] x_end_c, y_end_c, z_end_c;
   logic             in_crop_c, last_c;
   logic [PLANE_W-1:0] plane_ff;
   logic [VOL_W-1:0]   vol_ff;
   logic [IDX_W-1:0]   final_idx_c;

   // Item registers
   logic signed [SAMPLE_W-1:0] s_re_ff, s_im_ff, m_re_ff, m_im_ff;
   logic [POS_W-1:0]           dx_ff, dy_ff, dz_ff;
   logic                       in_crop_ff, first_ff, last_ff;
   logic signed [PROD_W-1:0]   prod_rr_ff, prod_ii_ff, prod_ir_ff, prod_ri_ff;
   logic [VOL_W-1:0]           iz_ff;
   logic [PLANE_W-1:0]         iy_ff;
   logic signed [TERM_W-1:0]   term_re_ff, term_im_ff;
   logic [SUM_IDX_W-1:0]       idx_sum_c;
   logic [IDX_W-1:0]           idx_ff;
   logic                       in_range_ff;
   logic signed [ACC_W-1:0]    acc_re_ff, acc_im_ff;
   logic signed [ACC_W-1:0]    rd_re_c, rd_im_c;
   logic [2*ACC_W-1:0]         rd_ff;

   // Voxel store: imaginary sum in the upper half
   logic [2*ACC_W-1:0] store_mem [MEM_DEPTH];

   // Square root
   logic [RAD_W-1:0]  radicand_c;
   logic [ROOT_W-1:0] root_c;
   logic              root_done_c;

   // Output register
   logic                    rsp_valid_ff;
   logic signed [ACC_W-1:0] rsp_re_ff, rsp_im_ff;
   logic [IDX_W-1:0]        rsp_idx_ff;
   logic                    rsp_last_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= DIM_W'(64);
         image_height_ff  <= DIM_W'(64);
         image_depth_ff   <= DIM_W'(16);
         crop_width_ff    <= DIM_W'(64);
         crop_height_ff   <= DIM_W'(64);
         crop_depth_ff    <= DIM_W'(16);
         channel_count_ff <= CNT_W'(1);
         root_mode_ff     <= 1'b0;
      end else if (csr_wen) begin
         case (cfg_index_type'(csr_index))
            CFG_IMAGE_WIDTH:   image_width_ff   <= csr_wdata;
            CFG_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata;
            CFG_IMAGE_DEPTH:   image_depth_ff   <= csr_wdata;
            CFG_CROP_WIDTH:    crop_width_ff    <= csr_wdata;
            CFG_CROP_HEIGHT:   crop_height_ff   <= csr_wdata;
            CFG_CROP_DEPTH:    crop_depth_ff    <= csr_wdata;
            CFG_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CNT_W-1:0];
            CFG_ROOT_MODE:     root_mode_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective sizes, centred crop window and channel position
   always_comb begin
      iw_c    = dim_eff(image_width_ff);
      ih_c    = dim_eff(image_height_ff);
      id_c    = dim_eff(image_depth_ff);
      cw_c    = crop_eff(crop_width_ff, iw_c);
      ch_c    = crop_eff(crop_height_ff, ih_c);
      cd_c    = crop_eff(crop_depth_ff, id_c);
      nch_c   = channel_count_ff;
      if (channel_count_ff == '0)
         nch_c = CNT_W'(1);
      else if (channel_count_ff > CNT_W'(MAX_CHANNELS))
         nch_c = CNT_W'(MAX_CHANNELS);
      x0_c    = POS_W'((iw_c - cw_c) >> 1);
      y0_c    = POS_W'((ih_c - ch_c) >> 1);
      z0_c    = POS_W'((id_c - cd_c) >> 1);
      x_end_c = DIM_W'(x0_c) + cw_c;
      y_end_c = DIM_W'(y0_c) + ch_c;
      z_end_c = DIM_W'(z0_c) + cd_c;
      in_crop_c = (pos_x_ff >= x0_c) && (DIM_W'(pos_x_ff) < x_end_c) &&
                  (pos_y_ff >= y0_c) && (DIM_W'(pos_y_ff) < y_end_c) &&
                  (pos_z_ff >= z0_c) && (DIM_W'(pos_z_ff) < z_end_c);
      last_c  = (CNT_W'(channel_ff) + CNT_W'(1)) >= nch_c;
   end

   // Raster advance: x fastest, then y, z, then channel
   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      pos_z_in   = pos_z_ff;
      channel_in = channel_ff;
      if (cmd.load_item) begin
         if (DIM_W'(pos_x_ff) + DIM_W'(1) >= iw_c) begin
            pos_x_in = '0;
            if (DIM_W'(pos_y_ff) + DIM_W'(1) >= ih_c) begin
               pos_y_in = '0;
               if (DIM_W'(pos_z_ff) + DIM_W'(1) >= id_c) begin
                  pos_z_in   = '0;
                  channel_in = last_c ? '0 : CHAN_W'(channel_ff + 1'b1);
               end else begin
                  pos_z_in = POS_W'(pos_z_ff + 1'b1);
               end
            end else begin
               pos_y_in = POS_W'(pos_y_ff + 1'b1);
            end
         end else begin
            pos_x_in = POS_W'(pos_x_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         pos_z_ff   <= '0;
         channel_ff <= '0;
      end else begin
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         pos_z_ff   <= pos_z_in;
         channel_ff <= channel_in;
      end
   end

   // Crop plane and volume, one multiplier per stage
   always_ff @(posedge clock) begin
      plane_ff <= PLANE_W'(PLANE_W'(cw_c) * PLANE_W'(ch_c));
      vol_ff   <= VOL_W'(VOL_W'(plane_ff) * VOL_W'(cd_c));
   end

   // Index of the last voxel that fits the store
   assign final_idx_c = (vol_ff < VOL_W'(MEM_DEPTH)) ? IDX_W'(vol_ff - 1'b1)
                                                     : IDX_W'(MEM_DEPTH - 1);

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         s_re_ff    <= req_tdata[0*SAMPLE_W +: SAMPLE_W];
         s_im_ff    <= req_tdata[1*SAMPLE_W +: SAMPLE_W];
         m_re_ff    <= req_tdata[2*SAMPLE_W +: SAMPLE_W];
         m_im_ff    <= req_tdata[3*SAMPLE_W +: SAMPLE_W];
         dx_ff      <= POS_W'(pos_x_ff - x0_c);
         dy_ff      <= POS_W'(pos_y_ff - y0_c);
         dz_ff      <= POS_W'(pos_z_ff - z0_c);
         in_crop_ff <= in_crop_c;
         first_ff   <= (channel_ff == '0);
         last_ff    <= last_c;
      end
   end

   // Products of sample and conjugate map, and index partial products
   always_ff @(posedge clock) begin
      if (cmd.multiply) begin
         prod_rr_ff <= PROD_W'(s_re_ff) * PROD_W'(m_re_ff);
         prod_ii_ff <= PROD_W'(s_im_ff) * PROD_W'(m_im_ff);
         prod_ir_ff <= PROD_W'(s_im_ff) * PROD_W'(m_re_ff);
         prod_ri_ff <= PROD_W'(s_re_ff) * PROD_W'(m_im_ff);
         iz_ff      <= VOL_W'(VOL_W'(dz_ff) * VOL_W'(plane_ff));
         iy_ff      <= PLANE_W'(PLANE_W'(dy_ff) * PLANE_W'(cw_c));
      end
   end

   // Complex terms and linear crop index
   assign idx_sum_c = SUM_IDX_W'(iz_ff) + SUM_IDX_W'(iy_ff) + SUM_IDX_W'(dx_ff);

   always_ff @(posedge clock) begin
      if (cmd.combine) begin
         term_re_ff  <= TERM_W'(prod_rr_ff) + TERM_W'(prod_ii_ff);
         term_im_ff  <= TERM_W'(prod_ir_ff) - TERM_W'(prod_ri_ff);
         idx_ff      <= idx_sum_c[IDX_W-1:0];
         in_range_ff <= in_crop_ff && (idx_sum_c[SUM_IDX_W-1:IDX_W] == '0);
      end
   end

   // Store read and write
   always_ff @(posedge clock) begin
      if (cmd.mem_read)
         rd_ff <= store_mem[idx_ff];
      if (cmd.mem_write)
         store_mem[idx_ff] <= {acc_im_ff, acc_re_ff};
   end

   assign rd_re_c = rd_ff[ACC_W-1:0];
   assign rd_im_c = rd_ff[2*ACC_W-1:ACC_W];

   // First channel writes, later ones add with saturation
   always_ff @(posedge clock) begin
      if (cmd.accum) begin
         if (first_ff) begin
            acc_re_ff <= ACC_W'(term_re_ff);
            acc_im_ff <= ACC_W'(term_im_ff);
         end else begin
            acc_re_ff <= sat((ACC_W+1)'(rd_re_c) + (ACC_W+1)'(term_re_ff));
            acc_im_ff <= sat((ACC_W+1)'(rd_im_c) + (ACC_W+1)'(term_im_ff));
         end
      end
   end

   // Root of the real sum; negative sums give zero
   assign radicand_c = acc_re_ff[ACC_W-1] ? '0 : acc_re_ff[RAD_W-1:0];

   ccca_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (radicand_c),
      .root     (root_c),
      .done     (root_done_c)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.emit)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_re_ff   <= root_mode_ff ? ACC_W'(root_c) : acc_re_ff;
         rsp_im_ff   <= root_mode_ff ? '0 : acc_im_ff;
         rsp_idx_ff  <= idx_ff;
         rsp_last_ff <= (idx_ff == final_idx_c);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_idx_ff, rsp_im_ff, rsp_re_ff});
   assign rsp_tlast  = rsp_last_ff;

   // Status to the controller
   assign status.in_range  = in_range_ff;
   assign status.last_ch   = last_ff;
   assign status.root_mode = root_mode_ff;
   assign status.root_done = root_done_c;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

[rtl/ccca_ctrl.sv]
// Controller: sequences one input transfer through the datapath.
`timescale 1ns / 1ps

module ccca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ccca_pkg::status_type  status,
   output ccca_pkg::cmd_type     cmd
);
   import ccca_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_PRODUCT = 8'b0000_0010,
      ST_INDEX   = 8'b0000_0100,
      ST_FETCH   = 8'b0000_1000,
      ST_ACCUM   = 8'b0001_0000,
      ST_STORE   = 8'b0010_0000,
      ST_ROOT    = 8'b0100_0000,
      ST_EMIT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_PRODUCT;
            end
         end
         ST_PRODUCT: begin
            cmd.multiply = 1'b1;
            state_in     = ST_INDEX;
         end
         ST_INDEX: begin
            cmd.combine = 1'b1;
            state_in    = ST_FETCH;
         end
         ST_FETCH: begin
            // voxels outside the crop or the store end here
            if (status.in_range) begin
               cmd.mem_read = 1'b1;
               state_in     = ST_ACCUM;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = ST_STORE;
         end
         ST_STORE: begin
            cmd.mem_write = 1'b1;
            if (!status.last_ch) begin
               state_in = ST_IDLE;
            end else if (status.root_mode) begin
               cmd.root_start = 1'b1;
               state_in       = ST_ROOT;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_ROOT: begin
            if (status.root_done)
               state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for room in the output register
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

[rtl/cropped_coil_combine_accumulator.sv]
// Top level of the cropped coil-combine accumulator.
`timescale 1ns / 1ps

// Coil-combine accumulator over a centred crop window.
// req_ carries one voxel per transfer: coil sample and coil map value, each
// complex Q1.15, channel by channel, each channel in z, y, x raster order
// over the full image. Crop voxels accumulate sample * conj(map) into a
// 65536-entry voxel store with saturation; on the last channel each stored
// crop voxel leaves on rsp_ as the complex sum, or in root mode as the integer
// square root of the real sum, with its crop index and a last-voxel flag.
// csr_ writes the geometry, channel count and mode; write only when idle.
// Each transfer passes the load, product, index and fetch states; crop
// voxels go on through accumulate and store, on the last channel also emit,
// with root before emit in root mode; the digit-serial root takes one result
// bit a cycle, and the store's single registered port sets the other steps.
// The result sits in an output register, so the next transfer is taken while
// a result waits; a stall on rsp_ holds the block only when a second result
// is ready to go out. Reset restores the register defaults and the raster
// and channel counters; the voxel store is not cleared, since the first
// channel always writes an entry before any later channel reads it.
module cropped_coil_combine_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wen,
   input  logic [ccca_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [ccca_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample_re, sample_im, map_re, map_im
   input  logic [ccca_pkg::REQ_DATA_W-1:0]     req_tdata,
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_re, result_im, voxel_index, zero fill
   output logic [ccca_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // last_voxel
   output logic                                rsp_tlast
);
   import ccca_pkg::*;

   cmd_type    cmd;
   status_type status;

   ccca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ccca_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

[bench/cropped_coil_combine_accumulator_tb.sv]
// Self-checking testbench for the cropped coil-combine accumulator.
`timescale 1ns / 1ps

module cropped_coil_combine_accumulator_tb;
   import ccca_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500_000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned SETTLE_CYC  = 40;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam longint ACC_TOP    = (64'sd1 <<< (ACC_W - 1)) - 1;
   localparam longint ACC_BOTTOM = -(64'sd1 <<< (ACC_W - 1));

   // One voxel transfer; packed so that sample_re lands in the lowest bits
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] map_im;
      logic signed [SAMPLE_W-1:0] map_re;
      logic signed [SAMPLE_W-1:0] sample_im;
      logic signed [SAMPLE_W-1:0] sample_re;
   } voxel_item_type;

   typedef struct {
      logic signed [ACC_W-1:0] re;
      logic signed [ACC_W-1:0] im;
      logic [IDX_W-1:0]        index;
      logic                    last;
   } coil_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_wen    = 1'b0;
   logic [CFG_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   cropped_coil_combine_accumulator u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // Register shadows, as written
   logic [DIM_W-1:0] image_w_reg = 11'd64, image_h_reg = 11'd64, image_d_reg = 11'd16;
   logic [DIM_W-1:0] crop_w_reg  = 11'd64, crop_h_reg  = 11'd64, crop_d_reg  = 11'd16;
   logic [CNT_W-1:0] channels_reg = 6'd1;
   logic             root_mode_reg = 1'b0;

   // Raster and channel position, voxel sums
   int unsigned      pos_x = 0, pos_y = 0, pos_z = 0;
   logic [CHAN_W-1:0] channel_pos = '0;
   longint           voxel_sum_re [MEM_DEPTH];
   longint           voxel_sum_im [MEM_DEPTH];

   voxel_item_type   voxel_queue [$];
   coil_result_type  combined_results [$];
   voxel_item_type   offered;
   coil_result_type  seen, wanted;

   int unsigned items_queued = 0, items_accepted = 0;
   int unsigned fault_count = 0;
   int unsigned idle_percent = 0;
   int unsigned holds_requested = 0, holds_served = 0;
   int unsigned send_gap = 0, stall_left = 0;
   int unsigned cycle_count = 0;

   function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return v;
   endfunction

   function automatic int unsigned active_channels();
      int unsigned n;
      n = (channels_reg == 0) ? 1 : channels_reg;
      if (n > MAX_CHANNELS) n = MAX_CHANNELS;
      return n;
   endfunction

   function automatic int unsigned frame_length();
      return active_channels() * eff_dim(image_w_reg) * eff_dim(image_h_reg)
             * eff_dim(image_d_reg);
   endfunction

   function automatic longint clamp_acc(longint v);
      if (v > ACC_TOP) return ACC_TOP;
      if (v < ACC_BOTTOM) return ACC_BOTTOM;
      return v;
   endfunction

   // Predicts the effect of one accepted voxel and advances the raster
   function automatic void combine_voxel(voxel_item_type v);
      int unsigned  iw, ih, id, cw, chh, cd, x0, y0, z0, idx, vol, final_idx;
      logic         first_ch, last_ch;
      longint       term_re, term_im, out_re, out_im, root, trial;
      coil_result_type r;
      iw = eff_dim(image_w_reg);
      ih = eff_dim(image_h_reg);
      id = eff_dim(image_d_reg);
      cw  = (crop_w_reg == 0) ? 1 : crop_w_reg;
      chh = (crop_h_reg == 0) ? 1 : crop_h_reg;
      cd  = (crop_d_reg == 0) ? 1 : crop_d_reg;
      if (cw > iw) cw = iw;
      if (chh > ih) chh = ih;
      if (cd > id) cd = id;
      x0 = (iw - cw) / 2;
      y0 = (ih - chh) / 2;
      z0 = (id - cd) / 2;
      first_ch = (channel_pos == 0);
      last_ch  = (channel_pos + 1 >= active_channels());

      if (pos_x >= x0 && pos_x < x0 + cw && pos_y >= y0 && pos_y < y0 + chh &&
          pos_z >= z0 && pos_z < z0 + cd) begin
         idx = (pos_z - z0) * cw * chh + (pos_y - y0) * cw + (pos_x - x0);
         vol = cw * chh * cd;
         final_idx = ((vol < MEM_DEPTH) ? vol : MEM_DEPTH) - 1;
         // voxels past the end of the store are dropped
         if (idx < MEM_DEPTH) begin
            term_re = longint'(v.sample_re) * v.map_re + longint'(v.sample_im) * v.map_im;
            term_im = longint'(v.sample_im) * v.map_re - longint'(v.sample_re) * v.map_im;
            if (first_ch) begin
               voxel_sum_re[idx] = term_re;
               voxel_sum_im[idx] = term_im;
            end else begin
               voxel_sum_re[idx] = clamp_acc(voxel_sum_re[idx] + term_re);
               voxel_sum_im[idx] = clamp_acc(voxel_sum_im[idx] + term_im);
            end
            if (last_ch) begin
               out_re = voxel_sum_re[idx];
               out_im = voxel_sum_im[idx];
               if (root_mode_reg) begin
                  // floor square root, one result bit at a time; negatives give zero
                  root = 0;
                  for (int b = ROOT_W; b >= 0; b--) begin
                     trial = root | (64'sd1 <<< b);
                     if (out_re > 0 && trial * trial <= out_re) root = trial;
                  end
                  out_re = root;
                  out_im = 0;
               end
               r.re    = out_re[ACC_W-1:0];
               r.im    = out_im[ACC_W-1:0];
               r.index = idx[IDX_W-1:0];
               r.last  = (idx == final_idx);
               combined_results.push_back(r);
            end
         end
      end

      if (pos_x + 1 >= iw) begin
         pos_x = 0;
         if (pos_y + 1 >= ih) begin
            pos_y = 0;
            if (pos_z + 1 >= id) begin
               pos_z = 0;
               channel_pos = last_ch ? '0 : channel_pos + 1'b1;
            end else begin
               pos_z++;
            end
         end else begin
            pos_y++;
         end
      end else begin
         pos_x++;
      end
   endfunction

   // Sender: offers queued voxels, with random gaps between transfers
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            combine_voxel(offered);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (voxel_queue.size() > 0) begin
               offered = voxel_queue.pop_front();
               req_tdata  <= offered;
               req_tvalid <= 1'b1;
               if (idle_percent != 0 && $urandom_range(99) < idle_percent)
                  send_gap = $urandom_range(1, 5);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result transfer, stalls in bursts or for a long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.re    = rsp_tdata[ACC_W-1:0];
            seen.im    = rsp_tdata[2*ACC_W-1:ACC_W];
            seen.index = rsp_tdata[2*ACC_W+IDX_W-1:2*ACC_W];
            seen.last  = rsp_tlast;
            if (combined_results.size() == 0) begin
               if (fault_count < 10)
                  $display("unexpected result: re %0d im %0d idx %0d last %0d",
                           seen.re, seen.im, seen.index, seen.last);
               fault_count++;
            end else begin
               wanted = combined_results.pop_front();
               if (seen.re !== wanted.re || seen.im !== wanted.im ||
                   seen.index !== wanted.index || seen.last !== wanted.last) begin
                  if (fault_count < 10)
                     $display("mismatch: expected re %0d im %0d idx %0d last %0d, got re %0d im %0d idx %0d last %0d",
                              wanted.re, wanted.im, wanted.index, wanted.last,
                              seen.re, seen.im, seen.index, seen.last);
                  fault_count++;
               end
            end
         end
         if (holds_served < holds_requested) begin
            holds_served++;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_percent != 0 && $urandom_range(99) < idle_percent) begin
            stall_left = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return '0;
         3: return '1;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic queue_voxel(logic signed [SAMPLE_W-1:0] s_re, logic signed [SAMPLE_W-1:0] s_im,
                              logic signed [SAMPLE_W-1:0] m_re, logic signed [SAMPLE_W-1:0] m_im);
      voxel_item_type v;
      v.sample_re = s_re;
      v.sample_im = s_im;
      v.map_re    = m_re;
      v.map_im    = m_im;
      voxel_queue.push_back(v);
      items_queued++;
   endtask

   task automatic queue_random(int unsigned count);
      for (int unsigned n = 0; n < count; n++)
         queue_voxel(random_sample(), random_sample(), random_sample(), random_sample());
   endtask

   // Waits for every transfer and result, then lets the pipeline empty
   task automatic settle_block();
      while (items_accepted != items_queued || combined_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   task automatic write_register(cfg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         CFG_IMAGE_WIDTH:   image_w_reg   = value;
         CFG_IMAGE_HEIGHT:  image_h_reg   = value;
         CFG_IMAGE_DEPTH:   image_d_reg   = value;
         CFG_CROP_WIDTH:    crop_w_reg    = value;
         CFG_CROP_HEIGHT:   crop_h_reg    = value;
         CFG_CROP_DEPTH:    crop_d_reg    = value;
         CFG_CHANNEL_COUNT: channels_reg  = value[CNT_W-1:0];
         CFG_ROOT_MODE:     root_mode_reg = value[0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(int unsigned iw, int unsigned ih, int unsigned id,
                               int unsigned cw, int unsigned ch, int unsigned cd,
                               int unsigned nch, int unsigned mode);
      write_register(CFG_IMAGE_WIDTH,   CSR_DATA_W'(iw));
      write_register(CFG_IMAGE_HEIGHT,  CSR_DATA_W'(ih));
      write_register(CFG_IMAGE_DEPTH,   CSR_DATA_W'(id));
      write_register(CFG_CROP_WIDTH,    CSR_DATA_W'(cw));
      write_register(CFG_CROP_HEIGHT,   CSR_DATA_W'(ch));
      write_register(CFG_CROP_DEPTH,    CSR_DATA_W'(cd));
      write_register(CFG_CHANNEL_COUNT, CSR_DATA_W'(nch));
      write_register(CFG_ROOT_MODE,     CSR_DATA_W'(mode));
   endtask

   initial begin
      int unsigned random_items, px, py, pz, pad;
      random_items = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Field extremes, complex sum
      set_geometry(4, 1, 1, 4, 1, 1, 1, 0);
      queue_voxel(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
      queue_voxel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      queue_voxel(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
      queue_voxel(16'sd0, -16'sd1, 16'sd1, 16'sd0);
      settle_block();

      // Root mode, including a negative real sum
      write_register(CFG_ROOT_MODE, CSR_DATA_W'(1));
      queue_voxel(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
      queue_voxel(SAMPLE_MIN, 16'sd0, SAMPLE_MAX, 16'sd0);
      queue_voxel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      queue_voxel(16'sd1, 16'sd0, 16'sd1, 16'sd0);
      settle_block();

      // All sizes zero behave as one
      set_geometry(0, 0, 0, 0, 0, 0, 0, 0);
      queue_random(1);
      settle_block();

      // Channel count above the maximum; full-scale products saturate the sum
      set_geometry(1, 1, 1, 1, 1, 1, 63, 0);
      for (int n = 0; n < 32; n++) queue_voxel(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
      settle_block();
      write_register(CFG_ROOT_MODE, CSR_DATA_W'(1));
      for (int n = 0; n < 32; n++) queue_voxel(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
      settle_block();

      // Oversized image and crop clip to the limit; the start of a frame is enough
      idle_percent = 10;
      set_geometry(2047, 1, 1, 1500, 1, 1, 1, 0);
      queue_random(24);
      settle_block();
      set_geometry(1, 1024, 1, 1, 1000, 1, 1, 1);
      queue_random(24);
      settle_block();
      // a single-voxel image brings the raster back to its origin
      set_geometry(1, 1, 1, 1, 1, 1, 1, 0);
      queue_random(1);
      settle_block();

      // Channel count lowered between channels: the current channel becomes the last
      set_geometry(3, 2, 2, 2, 2, 1, 4, 0);
      queue_random(24);
      settle_block();
      write_register(CFG_CHANNEL_COUNT, CSR_DATA_W'(2));
      queue_random(12);
      settle_block();

      // Geometry changed mid-frame; counters beyond the new size wrap
      set_geometry(5, 4, 2, 3, 2, 2, 1, 0);
      queue_random(13);
      settle_block();
      set_geometry(3, 2, 1, 2, 2, 1, 1, 1);
      queue_random(7);
      settle_block();
      px = pos_x;
      py = pos_y;
      pz = pos_z;
      pad = 0;
      while (px != 0 || py != 0 || pz != 0) begin
         if (px + 1 >= eff_dim(image_w_reg)) begin
            px = 0;
            if (py + 1 >= eff_dim(image_h_reg)) begin
               py = 0;
               if (pz + 1 >= eff_dim(image_d_reg)) pz = 0;
               else pz++;
            end else begin
               py++;
            end
         end else begin
            px++;
         end
         pad++;
      end
      queue_random(pad);
      settle_block();

      // Output held off for a long stretch while voxels keep coming
      idle_percent = 0;
      set_geometry(8, 6, 2, 6, 4, 2, 1, 0);
      holds_requested++;
      queue_random(frame_length());
      random_items += frame_length();
      settle_block();

      // Random geometry, channel count and mode
      while (random_items < 200) begin
         case ($urandom_range(0, 2))
            0: idle_percent = 0;
            1: idle_percent = 10;
            default: idle_percent = 30;
         endcase
         set_geometry($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 3),
                      $urandom_range(0, 7), $urandom_range(0, 5), $urandom_range(0, 4),
                      $urandom_range(0, 3), $urandom_range(0, 1));
         queue_random(frame_length());
         random_items += frame_length();
         settle_block();
      end

      // Closing stretch at full rate
      idle_percent = 0;
      set_geometry(4, 3, 2, 3, 2, 2, 2, 1);
      queue_random(frame_length());
      settle_block();
      set_geometry(3, 2, 2, 2, 2, 1, 2, 0);
      queue_random(frame_length());
      settle_block();

      if (fault_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
